// ===== design/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// shared types, character codes and helper functions of the sentence parser
// ----------------------------------------------------------------------------
package nsp_pkg;

   localparam int BUFFER_BYTES = 128;
   localparam int CNT_W        = $clog2(BUFFER_BYTES);
   localparam int LEN_W        = 7;
   localparam int LEN_MAX      = (1 << LEN_W) - 1;
   localparam int TALKER_LEN   = 2;
   localparam int CSUM_DIGITS  = 2;

   localparam logic [7:0] CHR_DOLLAR = 8'h24;
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_COMMA  = 8'h2C;
   localparam logic [7:0] CHR_LF     = 8'h0A;
   localparam logic [7:0] CHR_CR     = 8'h0D;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'b00001,
      PH_TALKER   = 5'b00010,
      PH_TYPE     = 5'b00100,
      PH_FIELDS   = 5'b01000,
      PH_CHECKSUM = 5'b10000
   } phase_type;

   typedef enum logic [3:0] {
      EV_IGNORED     = 4'd0,
      EV_START       = 4'd1,
      EV_TALKER_CHAR = 4'd2,
      EV_TALKER_DONE = 4'd3,
      EV_TYPE_CHAR   = 4'd4,
      EV_TYPE_DONE   = 4'd5,
      EV_FIELD_CHAR  = 4'd6,
      EV_FIELD_DONE  = 4'd7,
      EV_CSUM_CHAR   = 4'd8,
      EV_SENT_END    = 4'd9,
      EV_OVERFLOW    = 4'd10
   } event_type;

   typedef struct packed {
      phase_type        phase;
      logic [CNT_W-1:0] char_count;
      logic [7:0]       running_xor;
      logic [7:0]       field_counter;
      logic [7:0]       hex_high;
      logic [7:0]       hex_low;
   } state_type;

   typedef struct packed {
      event_type        event_res;
      logic [7:0]       char_out;
      logic [7:0]       field_number;
      logic [LEN_W-1:0] token_length;
      logic             checksum_ok;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      phase:         PH_IDLE,
      char_count:    '0,
      running_xor:   '0,
      field_counter: '0,
      hex_high:      '0,
      hex_low:       '0
   };

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   // letters have low nibble 1..6 for a..f and A..F
   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         v = c[3:0] + 4'd9;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c[3:0];
      end
      return v;
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] n);
      logic [LEN_W-1:0] r;
      if (32'(n) > LEN_MAX) begin
         r = LEN_W'(LEN_MAX);
      end else begin
         r = LEN_W'(n);
      end
      return r;
   endfunction

endpackage

// ===== design/nsp_channels.sv =====
// ----------------------------------------------------------------------------
// nsp channels
// valid/ready request and response channels of the sentence parser
// ----------------------------------------------------------------------------
interface nsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;

   modport source (output valid, output character, input ready);
   modport sink   (input valid, input character, output ready);
endinterface

interface nsp_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] event_res;
   logic [7:0] char_out;
   logic [7:0] field_number;
   logic [6:0] token_length;
   logic       checksum_ok;

   modport source (output valid, output event_res, output char_out,
                   output field_number, output token_length, output checksum_ok,
                   input ready);
   modport sink   (input valid, input event_res, input char_out,
                   input field_number, input token_length, input checksum_ok,
                   output ready);
endinterface

// ===== design/nsp_step.sv =====
// ----------------------------------------------------------------------------
// nsp_step
// per-character next state and event of the sentence parser
// ----------------------------------------------------------------------------
module nsp_step (
   input  nsp_pkg::state_type  state_cur,
   input  logic [7:0]          character,
   output nsp_pkg::state_type  state_nxt,
   output nsp_pkg::result_type result
);
   import nsp_pkg::*;

   localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(BUFFER_BYTES - 1);
   localparam logic [CNT_W-1:0] CNT_TALKER = CNT_W'(TALKER_LEN);
   localparam logic [CNT_W-1:0] CNT_DIGITS = CNT_W'(CSUM_DIGITS);

   logic [CNT_W-1:0] count_inc;
   logic [7:0]       xor_upd;
   logic [7:0]       want;

   assign count_inc = state_cur.char_count + 1'b1;
   assign xor_upd   = state_cur.running_xor ^ character;
   assign want      = {hex_val(state_cur.hex_high), hex_val(state_cur.hex_low)};

   always_comb begin
      state_nxt           = state_cur;
      result.event_res    = EV_IGNORED;
      result.char_out     = character;
      result.field_number = state_cur.field_counter;
      result.token_length = '0;
      result.checksum_ok  = 1'b0;

      if (state_cur.phase != PH_IDLE && state_cur.char_count >= CNT_LIMIT) begin
         result.event_res    = EV_OVERFLOW;
         result.token_length = sat_len(state_cur.char_count);
         state_nxt           = STATE_CLEAR;
      end else begin
         unique case (state_cur.phase)
            PH_IDLE: begin
               if (character == CHR_DOLLAR) begin
                  result.event_res        = EV_START;
                  result.field_number     = '0;
                  state_nxt.phase         = PH_TALKER;
                  state_nxt.char_count    = '0;
                  state_nxt.running_xor   = '0;
                  state_nxt.field_counter = '0;
               end
            end
            PH_TALKER: begin
               state_nxt.running_xor = xor_upd;
               if (count_inc >= CNT_TALKER) begin
                  result.event_res     = EV_TALKER_DONE;
                  result.token_length  = LEN_W'(TALKER_LEN);
                  state_nxt.char_count = '0;
                  state_nxt.phase      = PH_TYPE;
               end else begin
                  result.event_res     = EV_TALKER_CHAR;
                  state_nxt.char_count = count_inc;
               end
            end
            PH_TYPE: begin
               state_nxt.running_xor = xor_upd;
               if (character == CHR_COMMA) begin
                  result.event_res     = EV_TYPE_DONE;
                  result.token_length  = sat_len(state_cur.char_count);
                  state_nxt.char_count = '0;
                  state_nxt.phase      = PH_FIELDS;
               end else begin
                  result.event_res     = EV_TYPE_CHAR;
                  state_nxt.char_count = count_inc;
               end
            end
            PH_FIELDS: begin
               if (character == CHR_STAR) begin
                  result.event_res        = EV_FIELD_DONE;
                  result.token_length     = sat_len(state_cur.char_count);
                  state_nxt.char_count    = '0;
                  state_nxt.field_counter = '0;
                  state_nxt.phase         = PH_CHECKSUM;
                  state_nxt.hex_high      = '0;
                  state_nxt.hex_low       = '0;
               end else if (character == CHR_COMMA) begin
                  result.event_res      = EV_FIELD_DONE;
                  result.token_length   = sat_len(state_cur.char_count);
                  state_nxt.char_count  = '0;
                  state_nxt.running_xor = xor_upd;
                  if (state_cur.field_counter != 8'hFF) begin
                     state_nxt.field_counter = state_cur.field_counter + 8'd1;
                  end
               end else begin
                  result.event_res      = EV_FIELD_CHAR;
                  state_nxt.running_xor = xor_upd;
                  state_nxt.char_count  = count_inc;
               end
            end
            PH_CHECKSUM: begin
               if (character == CHR_LF) begin
                  result.event_res    = EV_SENT_END;
                  result.token_length = sat_len(state_cur.char_count);
                  result.checksum_ok  = (state_cur.char_count >= CNT_DIGITS) &&
                                        is_hex(state_cur.hex_high) &&
                                        is_hex(state_cur.hex_low) &&
                                        (want == state_cur.running_xor);
                  state_nxt           = STATE_CLEAR;
               end else if (character != CHR_CR) begin
                  result.event_res = EV_CSUM_CHAR;
                  if (state_cur.char_count == '0) begin
                     state_nxt.hex_high = character;
                  end else if (state_cur.char_count == CNT_W'(1)) begin
                     state_nxt.hex_low = character;
                  end
                  state_nxt.char_count = count_inc;
               end
            end
            default: begin
               state_nxt = STATE_CLEAR;
            end
         endcase
      end
   end

endmodule

// ===== design/nmea_sentence_parser_top.sv =====
// response: registered, valid in the cycle after its request is accepted
// throughput: one request per cycle while the receiver takes responses; a new request
//    is taken while the response register is being drained
// reset: synchronous active high; returns to idle with all counters cleared
//    and the response register empty
// ----------------------------------------------------------------------------
// nmea_sentence_parser_top
// streaming sentence parser, one event per received character
// ----------------------------------------------------------------------------
module nmea_sentence_parser_top (
   input logic      clock,
   input logic      reset,
   nsp_req_if.sink  req_chan,
   nsp_rsp_if.source rsp_chan
);
   import nsp_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   state_type  state_step;
   result_type result_step;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_accept;

   nsp_step u_step (
      .state_cur (state_ff),
      .character (req_chan.character),
      .state_nxt (state_step),
      .result    (result_step)
   );

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign state_in       = req_accept ? state_step : state_ff;
   assign rsp_valid_in   = req_accept || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_step;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_res    = result_ff.event_res;
   assign rsp_chan.char_out     = result_ff.char_out;
   assign rsp_chan.field_number = result_ff.field_number;
   assign rsp_chan.token_length = result_ff.token_length;
   assign rsp_chan.checksum_ok  = result_ff.checksum_ok;

`ifndef NO_ASSERTIONS
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff && result_ff.char_out == $past(req_chan.character))
      else $error("response missing after accepted request");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      32'(state_ff.char_count) <= BUFFER_BYTES - 1)
      else $error("character count beyond buffer limit");

   a_idle_ignore : assert property (@(posedge clock) disable iff (reset)
      req_accept && state_ff.phase == PH_IDLE && req_chan.character != CHR_DOLLAR
      |=> result_ff.event_res == EV_IGNORED && state_ff.phase == PH_IDLE)
      else $error("idle character not ignored");

   a_end_to_idle : assert property (@(posedge clock) disable iff (reset)
      req_accept && (result_step.event_res == EV_SENT_END ||
                     result_step.event_res == EV_OVERFLOW)
      |=> state_ff.phase == PH_IDLE && state_ff.char_count == '0)
      else $error("sentence end or overflow did not clear state");
`endif

endmodule

// ===== verif/nsp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsp_checker
// watches both channels of the sentence parser, predicts the event of every
// accepted request and compares each response field by field in order
// ----------------------------------------------------------------------------
module nsp_checker (
   input  logic clock,
   input  logic reset,
   nsp_req_if   req_mon,
   nsp_rsp_if   rsp_mon,
   output int   mismatches,
   output int   outstanding,
   output int   checked,
   output int   sentences,
   output int   sums_good,
   output int   overflows
);
   import nsp_pkg::*;

   result_type events_q[$];

   phase_type  ph;
   int         tok_count;
   logic [7:0] csum;
   logic [7:0] fidx;
   logic [7:0] hi_chr;
   logic [7:0] lo_chr;

   int n_err  = 0;
   int n_chk  = 0;
   int n_end  = 0;
   int n_good = 0;
   int n_ovf  = 0;

   function automatic void clear_parser();
      ph        = PH_IDLE;
      tok_count = 0;
      csum      = '0;
      fidx      = '0;
      hi_chr    = '0;
      lo_chr    = '0;
   endfunction

   function automatic logic [6:0] clip_len(input int n);
      return (n > LEN_MAX) ? 7'(LEN_MAX) : 7'(n);
   endfunction

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = {1'b1, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = {1'b1, 4'(c - 8'h61 + 8'd10)};
      end
      return d;
   endfunction

   function automatic result_type parse_char(input logic [7:0] c);
      result_type r;
      logic [4:0] dh;
      logic [4:0] dl;
      r.event_res    = EV_IGNORED;
      r.char_out     = c;
      r.field_number = fidx;
      r.token_length = '0;
      r.checksum_ok  = 1'b0;
      if (ph != PH_IDLE && tok_count >= BUFFER_BYTES - 1) begin
         r.event_res    = EV_OVERFLOW;
         r.token_length = clip_len(tok_count);
         clear_parser();
      end else begin
         case (ph)
            PH_IDLE: begin
               if (c == CHR_DOLLAR) begin
                  r.event_res    = EV_START;
                  r.field_number = '0;
                  ph             = PH_TALKER;
                  tok_count      = 0;
                  csum           = '0;
                  fidx           = '0;
               end
            end
            PH_TALKER: begin
               csum = csum ^ c;
               tok_count++;
               if (tok_count >= TALKER_LEN) begin
                  r.event_res    = EV_TALKER_DONE;
                  r.token_length = 7'(TALKER_LEN);
                  tok_count      = 0;
                  ph             = PH_TYPE;
               end else begin
                  r.event_res = EV_TALKER_CHAR;
               end
            end
            PH_TYPE: begin
               csum = csum ^ c;
               if (c == CHR_COMMA) begin
                  r.event_res    = EV_TYPE_DONE;
                  r.token_length = clip_len(tok_count);
                  tok_count      = 0;
                  ph             = PH_FIELDS;
               end else begin
                  r.event_res = EV_TYPE_CHAR;
                  tok_count++;
               end
            end
            PH_FIELDS: begin
               if (c == CHR_COMMA || c == CHR_STAR) begin
                  r.event_res    = EV_FIELD_DONE;
                  r.token_length = clip_len(tok_count);
                  tok_count      = 0;
                  if (c == CHR_STAR) begin
                     fidx   = '0;
                     ph     = PH_CHECKSUM;
                     hi_chr = '0;
                     lo_chr = '0;
                  end else begin
                     csum = csum ^ c;
                     if (fidx != 8'hFF) begin
                        fidx++;
                     end
                  end
               end else begin
                  r.event_res = EV_FIELD_CHAR;
                  csum        = csum ^ c;
                  tok_count++;
               end
            end
            default: begin
               if (c == CHR_LF) begin
                  r.event_res    = EV_SENT_END;
                  r.token_length = clip_len(tok_count);
                  dh             = digit_value(hi_chr);
                  dl             = digit_value(lo_chr);
                  if (tok_count >= CSUM_DIGITS && dh[4] && dl[4]) begin
                     r.checksum_ok = ({dh[3:0], dl[3:0]} == csum);
                  end
                  clear_parser();
               end else if (c != CHR_CR) begin
                  r.event_res = EV_CSUM_CHAR;
                  if (tok_count == 0) begin
                     hi_chr = c;
                  end else if (tok_count == 1) begin
                     lo_chr = c;
                  end
                  tok_count++;
               end
            end
         endcase
      end
      return r;
   endfunction

   function automatic void report(input string msg);
      n_err++;
      if (n_err <= 10) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         report($sformatf("response %0d %s expected %0h got %0h", n_chk, name, want, got));
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_parser();
         events_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (events_q.size() == 0) begin
               report($sformatf("response with no request outstanding, event %0h char %0h",
                                rsp_mon.event_res, rsp_mon.char_out));
            end else begin
               want = events_q.pop_front();
               check_field("event", 32'(want.event_res), 32'(rsp_mon.event_res));
               check_field("char", 32'(want.char_out), 32'(rsp_mon.char_out));
               check_field("field number", 32'(want.field_number),
                           32'(rsp_mon.field_number));
               check_field("token length", 32'(want.token_length),
                           32'(rsp_mon.token_length));
               check_field("checksum ok", 32'(want.checksum_ok), 32'(rsp_mon.checksum_ok));
               n_chk++;
               if (want.event_res == EV_SENT_END) begin
                  n_end++;
                  if (want.checksum_ok) begin
                     n_good++;
                  end
               end
               if (want.event_res == EV_OVERFLOW) begin
                  n_ovf++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            events_q.push_back(parse_char(req_mon.character));
         end
      end
      outstanding <= events_q.size();
      mismatches  <= n_err;
      checked     <= n_chk;
      sentences   <= n_end;
      sums_good   <= n_good;
      overflows   <= n_ovf;
   end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams sentences, broken sentences and noise into the parser with bursty
// requests and a stalling receiver; the checker judges every response
// ----------------------------------------------------------------------------
module testbench;
   import nsp_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int ITEM_TARGET  = 900;

   localparam int LONG_NONE  = 0;
   localparam int LONG_TYPE  = 1;
   localparam int LONG_FIELD = 2;
   localparam int LONG_CSUM  = 3;

   typedef enum int {
      CS_GOOD,
      CS_GOOD_CR,
      CS_WRONG,
      CS_ONE_DIGIT,
      CS_NONE,
      CS_NON_HEX
   } csum_style_type;

   typedef logic [7:0] text_type[$];

   logic clock;
   logic reset;

   nsp_req_if req_chan ();
   nsp_rsp_if rsp_chan ();

   int mismatches;
   int outstanding;
   int checked;
   int sentences;
   int sums_good;
   int overflows;

   int burst_left     = 0;
   int sentence_items = 0;
   int idle_cycles    = 0;
   int rx_mode        = 0;
   int rx_left        = 0;
   int rx_phase       = 0;

   nmea_sentence_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   nsp_checker event_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked),
      .sentences   (sentences),
      .sums_good   (sums_good),
      .overflows   (overflows)
   );

   always #4 clock = ~clock;

   // receiver stall pattern, switching at random between four ready modes
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rx_left == 0) begin
            rx_mode  = $urandom_range(0, 3);
            rx_left  = $urandom_range(20, 200);
            rx_phase = 0;
         end
         rx_left--;
         rx_phase++;
         case (rx_mode)
            0: begin
               rsp_chan.ready <= 1'b1;
            end
            1: begin
               rsp_chan.ready <= 1'($urandom_range(0, 1));
            end
            2: begin
               rsp_chan.ready <= ($urandom_range(0, 9) != 0);
            end
            default: begin
               rsp_chan.ready <= ((rx_phase % 16) >= 10);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   task automatic send_char(input logic [7:0] c);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_chan.valid     <= 1'b1;
      req_chan.character <= c;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_text(input text_type q, input bit counted);
      foreach (q[i]) begin
         send_char(q[i]);
      end
      if (counted) begin
         sentence_items += q.size();
      end
   endtask

   // hold off until every request has its response
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic void put_str(ref text_type q, input string s);
      for (int i = 0; i < s.len(); i++) begin
         q.push_back(s[i]);
      end
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
      logic [7:0] c;
      if (n < 10) begin
         c = 8'h30 + 8'(n);
      end else begin
         c = (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
      end
      return c;
   endfunction

   function automatic logic [7:0] body_char(input bit in_field);
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0: begin
            c = 8'($urandom_range(0, 255));
         end
         1, 2: begin
            c = 8'h30 + 8'($urandom_range(0, 9));
         end
         3: begin
            c = 8'h2E;
         end
         default: begin
            c = 8'h41 + 8'($urandom_range(0, 25));
         end
      endcase
      if (c == CHR_COMMA || (in_field && c == CHR_STAR)) begin
         c = 8'h2D;
      end
      return c;
   endfunction

   function automatic void frame_sentence(ref text_type q, input string body);
      logic [7:0] sum;
      sum = '0;
      q.push_back(CHR_DOLLAR);
      for (int i = 0; i < body.len(); i++) begin
         q.push_back(body[i]);
         sum = sum ^ body[i];
      end
      q.push_back(CHR_STAR);
      q.push_back(hex_char(sum[7:4], 1'b0));
      q.push_back(hex_char(sum[3:0], 1'b0));
      q.push_back(CHR_CR);
      q.push_back(CHR_LF);
   endfunction

   function automatic void make_sentence(ref text_type q, input int long_kind,
                                         input int n_empty);
      text_type       body;
      logic [7:0]     sum;
      logic [7:0]     shown;
      int             n;
      int             len;
      bit             lower;
      csum_style_type style;
      body.push_back(body_char(1'b0));
      body.push_back(body_char(1'b0));
      len = (long_kind == LONG_TYPE) ? $urandom_range(124, 132) : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
         body.push_back(body_char(1'b0));
      end
      body.push_back(CHR_COMMA);
      n = 1 + $urandom_range(0, 8) + n_empty;
      for (int f = 0; f < n; f++) begin
         if (long_kind == LONG_FIELD && f == 0) begin
            len = $urandom_range(124, 132);
         end else if (f < n_empty) begin
            len = 0;
         end else begin
            len = $urandom_range(0, 10);
         end
         for (int i = 0; i < len; i++) begin
            body.push_back(body_char(1'b1));
         end
         if (f != n - 1) begin
            body.push_back(CHR_COMMA);
         end
      end
      sum = '0;
      foreach (body[i]) begin
         sum = sum ^ body[i];
      end
      q.push_back(CHR_DOLLAR);
      foreach (body[i]) begin
         q.push_back(body[i]);
      end
      q.push_back(CHR_STAR);
      lower = 1'($urandom_range(0, 1));
      if (long_kind == LONG_CSUM) begin
         len = $urandom_range(124, 132);
         for (int i = 0; i < len; i++) begin
            q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
         end
      end else begin
         style = ($urandom_range(0, 1) == 0) ? CS_GOOD
                                             : csum_style_type'($urandom_range(0, 5));
         shown = (style == CS_WRONG) ? sum ^ (8'd1 << $urandom_range(0, 7)) : sum;
         case (style)
            CS_GOOD, CS_WRONG: begin
               q.push_back(hex_char(shown[7:4], lower));
               q.push_back(hex_char(shown[3:0], lower));
            end
            CS_GOOD_CR: begin
               q.push_back(hex_char(shown[7:4], lower));
               q.push_back(CHR_CR);
               q.push_back(hex_char(shown[3:0], lower));
            end
            CS_ONE_DIGIT: begin
               q.push_back(hex_char(shown[7:4], lower));
            end
            CS_NON_HEX: begin
               q.push_back(8'h47 + 8'($urandom_range(0, 19)));
               q.push_back(hex_char(shown[3:0], lower));
            end
            default: begin
            end
         endcase
         if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
               q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
            end
         end
      end
      if ($urandom_range(0, 1) == 1) begin
         q.push_back(CHR_CR);
      end
      q.push_back(CHR_LF);
   endfunction

   initial begin
      text_type msg;
      text_type resync;
      int       iter;
      int       pick;
      int       cut;
      clock              = 1'b0;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.character = '0;
      put_str(resync, "AA,*\n");
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme bytes in idle, a clean sentence, odd characters
      msg = {8'h00, 8'hFF};
      send_text(msg, 1'b1);
      msg = {};
      frame_sentence(msg, "GPGGA,1,");
      send_text(msg, 1'b1);
      msg = {};
      put_str(msg, "$A$*,*Z\n");
      send_text(msg, 1'b1);
      drain();

      iter = 0;
      while (sentence_items < ITEM_TARGET) begin
         msg = {};
         pick = $urandom_range(0, 99);
         if (iter == 0 || iter == 2 || iter == 3) begin
            make_sentence(msg, (iter == 0) ? LONG_FIELD : (iter == 2) ? LONG_TYPE
                                                                     : LONG_CSUM, 0);
            send_text(msg, 1'b1);
            send_text(resync, 1'b1);
         end else if (iter == 1) begin
            make_sentence(msg, LONG_NONE, 260);
            send_text(msg, 1'b1);
         end else if (pick < 70) begin
            make_sentence(msg, LONG_NONE, 0);
            send_text(msg, 1'b1);
         end else if (pick < 80) begin
            cut = $urandom_range(1, 8);
            for (int i = 0; i < cut; i++) begin
               send_char(8'($urandom_range(0, 255)));
            end
            sentence_items += cut;
            send_text(resync, 1'b1);
         end else if (pick < 95) begin
            make_sentence(msg, LONG_NONE, 0);
            cut = $urandom_range(1, msg.size() - 1);
            msg = msg[0:cut-1];
            send_text(msg, 1'b1);
            send_text(resync, 1'b1);
         end else if (pick < 97) begin
            make_sentence(msg, $urandom_range(LONG_TYPE, LONG_CSUM), 0);
            send_text(msg, 1'b1);
            send_text(resync, 1'b1);
         end else begin
            drain();
            make_sentence(msg, LONG_NONE, 0);
            send_text(msg, 1'b1);
         end
         iter++;
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      $display("run: %0d responses checked over %0d stimulus rounds", checked, iter);
      $display("run: %0d sentences ended, %0d with a matching checksum, %0d overflows",
               sentences, sums_good, overflows);
      if (mismatches == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
